// ===== src/stq_pkg.sv =====
`timescale 1ns / 1ps
package stq_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int TEMP_TIMERS = 4;
  localparam int PERM_TIMERS = NUM_TIMERS - TEMP_TIMERS;
  localparam int SLOT_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int POOL_IDX_W  = (TEMP_TIMERS > 1) ? $clog2(TEMP_TIMERS) : 1;
  localparam int POOL_CNT_W  = $clog2(TEMP_TIMERS + 1);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ABS    = 3'd1,
    OP_JIF    = 3'd2,
    OP_SEC    = 3'd3,
    OP_TEMP   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_CANCEL = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BIG     = 2'd1,
    ST_NOFREE  = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RS_SLOT,
    RS_ZERO,
    RS_ARM,
    RS_ENTRY
  } res_sel_t;

  typedef enum logic [1:0] {
    AT_ABS,
    AT_JIF,
    AT_SEC
  } arm_time_t;

  typedef enum logic {
    CFG_TPS   = 1'b0,
    CFG_MAXD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DEC,
    S_ASCAN,
    S_CSCAN,
    S_TCHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      mul;
    logic      tick_inc;
    logic      arm;
    logic      arm_temp;
    arm_time_t arm_time;
    logic      idx_clr;
    logic      idx_inc;
    logic      insert;
    logic      remove;
    logic      clear;
    logic      res_load;
    res_sel_t  res_sel;
    status_t   res_status;
    logic      res_kind;
    logic      out_load;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    op_t                 op;
    logic                slot_bad;
    logic                over_jif;
    logic                over_sec;
    logic                pool_empty;
    logic                idx_in;
    logic                after;
    logic                head_fire;
    logic                match;
    logic                out_free;
    logic [CNT_W-1:0]    queue_count;
    logic [POOL_CNT_W-1:0] free_count;
  } stat_t;

endpackage

// ===== src/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// sorted timer queue
// commands enter on the s_ channel (opcode in s_tuser), results leave on the
// m_ channel (kind in m_tuser, last result of a command in m_tlast).
// configuration: cfg_index 0 ticks per second, 1 max jiffy delay; cfg_ready is
// always high; the user must have writes taken only while no command is in
// flight, as the block itself does not enforce this. one command is handled
// at a time; s_tready is high only when idle. sets and cancels walk the
// expiry-ordered queue one entry per cycle; a tick fires the expired timers
// from the queue head one at a time. the set and tick scans read through the
// shared expiry read port.
// results sit in an output register; the next command is accepted while the
// last result still waits for m_tready. a tick firing several timers emits
// one transaction per timer and stalls its walk while the receiver stalls.
// reset clears the tick clock and the queue, refills the temporary pool and
// loads the registers with 100 ticks per second and the largest delay.
module sorted_timer_queue import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // slot, time_value, handler_id, handler_arg
  input  logic [2:0]  s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // status, timer_slot, fired_handler, fired_arg
  output logic        m_tuser,  // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  stq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_opcode (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid),
    .cfg_sel   (cfg_reg_t'(cfg_index)),
    .cfg_wdata (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("command accepted while busy");

  a_qcount: assert property (@(posedge clk) disable iff (rst)
    st.queue_count <= CNT_W'(NUM_TIMERS))
    else $error("queue count overflow");

  a_pool: assert property (@(posedge clk) disable iff (rst)
    st.free_count <= POOL_CNT_W'(TEMP_TIMERS))
    else $error("pool count overflow");

endmodule

// ===== src/stq_ctrl.sv =====
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.idx_clr = 1'b1;
        state_next  = S_RESP;
        cmd.res_load = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_sel = RS_SLOT;
        if (st.slot_bad) begin
          cmd.res_status = ST_NOMATCH;
        end else begin
          unique case (st.op)
            OP_TICK: begin
              cmd.res_load = 1'b0;
              cmd.tick_inc = 1'b1;
              state_next   = S_TCHK;
            end
            OP_ABS: begin
              cmd.res_load = 1'b0;
              cmd.arm      = 1'b1;
              cmd.arm_time = AT_ABS;
              state_next   = S_ASCAN;
            end
            OP_JIF: begin
              if (st.over_jif) begin
                cmd.res_status = ST_BIG;
              end else begin
                cmd.res_load = 1'b0;
                cmd.arm      = 1'b1;
                cmd.arm_time = AT_JIF;
                state_next   = S_ASCAN;
              end
            end
            OP_SEC: begin
              cmd.res_load = 1'b0;
              cmd.arm      = 1'b1;
              cmd.arm_time = AT_SEC;
              state_next   = S_ASCAN;
            end
            OP_TEMP: begin
              cmd.res_sel = RS_ZERO;
              if (st.pool_empty) begin
                cmd.res_status = ST_NOFREE;
              end else if (st.over_sec) begin
                cmd.res_status = ST_BIG;
              end else begin
                cmd.res_load = 1'b0;
                cmd.arm      = 1'b1;
                cmd.arm_temp = 1'b1;
                cmd.arm_time = AT_SEC;
                state_next   = S_ASCAN;
              end
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            OP_CANCEL: begin
              cmd.res_load = 1'b0;
              state_next   = S_CSCAN;
            end
            OP_NOP: begin
              cmd.res_sel = RS_ZERO;
            end
            default: begin
              cmd.res_sel = RS_ZERO;
            end
          endcase
        end
      end
      S_ASCAN: begin
        if (st.idx_in && st.after) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.insert     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RS_ARM;
          cmd.res_status = ST_OK;
          state_next     = S_RESP;
        end
      end
      S_CSCAN: begin
        cmd.res_load = 1'b1;
        state_next   = S_RESP;
        if (!st.idx_in) begin
          cmd.res_sel    = RS_ZERO;
          cmd.res_status = ST_NOMATCH;
        end else if (st.match) begin
          cmd.res_sel    = RS_ENTRY;
          cmd.res_status = ST_OK;
          cmd.remove     = 1'b1;
        end else begin
          cmd.res_load = 1'b0;
          cmd.idx_inc  = 1'b1;
          state_next   = S_CSCAN;
        end
      end
      S_TCHK: begin
        if (st.head_fire) begin
          if (!pend || st.out_free) begin
            cmd.out_load   = pend;
            cmd.out_last   = 1'b0;
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RS_ENTRY;
            cmd.res_kind   = 1'b1;
            cmd.res_status = ST_OK;
            cmd.remove     = 1'b1;
            pend_next      = 1'b1;
          end
        end else if (!pend) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          pend_next    = 1'b0;
          state_next   = S_IDLE;
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/stq_datapath.sv =====
`timescale 1ns / 1ps
module stq_datapath import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_data,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_sel,
  input  logic [31:0] cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_data,
  output logic        out_kind,
  output logic        out_last
);

  logic [15:0] tps;
  logic [30:0] max_delay;
  logic [31:0] cur_time;

  op_t         lat_op;
  logic [3:0]  lat_slot;
  logic [31:0] lat_tv;
  logic [7:0]  lat_h;
  logic [15:0] lat_a;
  logic [31:0] prod;

  logic [31:0] expiry [NUM_TIMERS];
  logic [7:0]  own_h  [NUM_TIMERS];
  logic [15:0] own_a  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active;
  logic [SLOT_W-1:0] q [NUM_TIMERS];
  logic [SLOT_W-1:0] q_next [NUM_TIMERS];
  logic [CNT_W-1:0]  count, count_next;
  logic [SLOT_W-1:0] pool [TEMP_TIMERS];
  logic [POOL_CNT_W-1:0] free_cnt;

  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] arm_slot;
  logic [31:0]       arm_t;
  logic [SLOT_W-1:0] arm_sel;
  logic [31:0]       arm_t_sel;
  logic [SLOT_W-1:0] rd_slot;
  logic [31:0]       d_after, d_fire;

  logic              do_unlink;
  logic [SLOT_W-1:0] uslot;
  logic [CNT_W-1:0]  upos;
  logic [CNT_W-1:0]  rpos;
  logic              shift_out;

  logic        res_kind;
  status_t     res_status;
  logic [3:0]  res_slot;
  logic [7:0]  res_h;
  logic [15:0] res_a;

  logic [POOL_IDX_W-1:0] pool_top;

  assign pool_top = POOL_IDX_W'(free_cnt - 1'b1);
  assign rd_slot  = q[idx[SLOT_W-1:0]];
  assign arm_sel  = cmd.arm_temp ? pool[pool_top] : SLOT_W'(lat_slot);

  always_comb begin
    unique case (cmd.arm_time)
      AT_ABS:  arm_t_sel = lat_tv;
      AT_JIF:  arm_t_sel = cur_time + lat_tv;
      AT_SEC:  arm_t_sel = cur_time + prod;
      default: arm_t_sel = lat_tv;
    endcase
  end

  assign d_after = arm_t - expiry[rd_slot];
  assign d_fire  = expiry[rd_slot] - cur_time;

  assign st.op          = lat_op;
  assign st.slot_bad    = (lat_op == OP_ABS || lat_op == OP_JIF || lat_op == OP_SEC ||
                           lat_op == OP_CLEAR) && (lat_slot >= 4'(PERM_TIMERS));
  assign st.over_jif    = lat_tv > {1'b0, max_delay};
  assign st.over_sec    = prod > {1'b0, max_delay};
  assign st.pool_empty  = (free_cnt == '0);
  assign st.idx_in      = idx < count;
  assign st.after       = (d_after != '0) && !d_after[31];
  assign st.head_fire   = (count != '0) && ((d_fire == '0) || d_fire[31]);
  assign st.match       = (own_h[rd_slot] == lat_h) && (own_a[rd_slot] == lat_a);
  assign st.out_free    = !out_valid || out_ready;
  assign st.queue_count = count;
  assign st.free_count  = free_cnt;

  // position of a slot being unlinked
  assign uslot     = cmd.arm ? arm_sel : SLOT_W'(lat_slot);
  assign do_unlink = (cmd.arm || cmd.clear) && active[uslot];

  always_comb begin
    upos = CNT_W'(NUM_TIMERS);
    for (int j = NUM_TIMERS - 1; j >= 0; j--) begin
      if (CNT_W'(j) < count && q[j] == uslot) upos = CNT_W'(j);
    end
  end

  assign shift_out = do_unlink || cmd.remove;
  assign rpos      = do_unlink ? upos : idx;

  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) q_next[j] = q[j];
    count_next = count;
    if (shift_out) begin
      for (int j = 0; j < NUM_TIMERS - 1; j++) begin
        if (CNT_W'(j) >= rpos) q_next[j] = q[j+1];
      end
      count_next = count - 1'b1;
    end else if (cmd.insert && count < CNT_W'(NUM_TIMERS)) begin
      for (int j = 1; j < NUM_TIMERS; j++) begin
        if (CNT_W'(j) > idx) q_next[j] = q[j-1];
      end
      q_next[idx[SLOT_W-1:0]] = arm_slot;
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps       <= 16'd100;
      max_delay <= 31'h7FFF_FFFF;
      cur_time  <= '0;
      active    <= '0;
      count     <= '0;
      free_cnt  <= POOL_CNT_W'(TEMP_TIMERS);
      for (int i = 0; i < TEMP_TIMERS; i++) pool[i] <= SLOT_W'(NUM_TIMERS - 1 - i);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          CFG_TPS:  tps       <= cfg_wdata[15:0];
          CFG_MAXD: max_delay <= cfg_wdata[30:0];
          default:  ;
        endcase
      end
      if (cmd.tick_inc) cur_time <= cur_time + 1'b1;
      count <= count_next;
      if (do_unlink) active[uslot] <= 1'b0;
      if (cmd.insert && count < CNT_W'(NUM_TIMERS)) active[arm_slot] <= 1'b1;
      if (cmd.remove) begin
        active[rd_slot] <= 1'b0;
        if (rd_slot >= SLOT_W'(PERM_TIMERS) && free_cnt < POOL_CNT_W'(TEMP_TIMERS)) begin
          pool[free_cnt[POOL_IDX_W-1:0]] <= rd_slot;
          free_cnt <= free_cnt + 1'b1;
        end
      end
      if (cmd.arm && cmd.arm_temp) free_cnt <= free_cnt - 1'b1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TIMERS; j++) q[j] <= q_next[j];
    if (cmd.latch) begin
      lat_op   <= op_t'(in_opcode);
      lat_slot <= in_data[3:0];
      lat_tv   <= in_data[35:4];
      lat_h    <= in_data[43:36];
      lat_a    <= in_data[59:44];
    end
    if (cmd.mul) prod <= 32'(lat_tv * tps);
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.arm) begin
      arm_slot        <= arm_sel;
      arm_t           <= arm_t_sel;
      expiry[arm_sel] <= arm_t_sel;
      own_h[arm_sel]  <= lat_h;
      own_a[arm_sel]  <= lat_a;
    end
    if (cmd.res_load) begin
      res_kind   <= cmd.res_kind;
      res_status <= cmd.res_status;
      unique case (cmd.res_sel)
        RS_SLOT: begin
          res_slot <= lat_slot;
          res_h    <= '0;
          res_a    <= '0;
        end
        RS_ZERO: begin
          res_slot <= '0;
          res_h    <= '0;
          res_a    <= '0;
        end
        RS_ARM: begin
          res_slot <= 4'(arm_slot);
          res_h    <= '0;
          res_a    <= '0;
        end
        RS_ENTRY: begin
          res_slot <= 4'(rd_slot);
          res_h    <= own_h[rd_slot];
          res_a    <= own_a[rd_slot];
        end
        default: begin
          res_slot <= '0;
          res_h    <= '0;
          res_a    <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_kind <= res_kind;
      out_last <= cmd.out_last;
      out_data <= {2'b00, res_a, res_h, res_slot, res_status};
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench import stq_pkg::*; ;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // slot, time_value, handler_id, handler_arg
  logic [2:0]  s_tuser = '0;  // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // status, timer_slot, fired_handler, fired_arg
  logic        m_tuser;       // kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  sorted_timer_queue DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [3:0]  tslot;
    logic [7:0]  hid;
    logic [15:0] harg;
    logic        last;
  } event_t;

  // timer state copy
  logic [15:0] tps;
  logic [30:0] maxd;
  logic [31:0] now;
  logic [31:0] due [NUM_TIMERS];
  logic [7:0]  own_h [NUM_TIMERS];
  logic [15:0] own_a [NUM_TIMERS];
  logic        busy [NUM_TIMERS];
  int          order [$];
  int          pool [$];

  event_t pending_events [$];
  int errors = 0, mismatches = 0, cycles = 0, n_items = 0, n_events = 0, n_fired = 0;
  bit calm = 0;

  function automatic void push_ev(logic k, status_t st, int s, logic [7:0] h,
                                  logic [15:0] a);
    event_t e;
    e.kind = k; e.status = st; e.tslot = s[3:0]; e.hid = h; e.harg = a; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic void drop_slot(int s);
    foreach (order[i]) if (order[i] == s) begin
      order.delete(i);
      break;
    end
    busy[s] = 1'b0;
  endfunction

  function automatic void retire_at(int p);
    int s;
    s = order[p];
    order.delete(p);
    busy[s] = 1'b0;
    if (s >= PERM_TIMERS && pool.size() < TEMP_TIMERS) pool.push_back(s);
  endfunction

  function automatic void queue_timer(int s, logic [31:0] t, logic [7:0] h, logic [15:0] a);
    int p;
    logic [31:0] d;
    if (busy[s]) drop_slot(s);
    due[s] = t; own_h[s] = h; own_a[s] = a;
    for (p = 0; p < order.size(); p++) begin
      d = t - due[order[p]];
      if (!(d != 0 && !d[31])) break;
    end
    order.insert(p, s);
    busy[s] = 1'b1;
  endfunction

  function automatic void predict(op_t op, logic [3:0] sl, logic [31:0] tv,
                                  logic [7:0] h, logic [15:0] a);
    int n, s, i, base;
    logic [31:0] d, dl;
    base = pending_events.size();
    if (op == OP_TICK) begin
      now = now + 1;
      n = 0;
      while (order.size() > 0 && n < 16) begin
        s = order[0];
        d = due[s] - now;
        if (d != 0 && !d[31]) break;
        push_ev(1'b1, ST_OK, s, own_h[s], own_a[s]);
        n++;
        retire_at(0);
      end
      n_fired += n;
    end else if (op inside {OP_ABS, OP_JIF, OP_SEC, OP_CLEAR} && sl >= PERM_TIMERS) begin
      push_ev(1'b0, ST_NOMATCH, sl, 0, 0);
    end else if (op == OP_ABS) begin
      queue_timer(sl, tv, h, a);
      push_ev(1'b0, ST_OK, sl, 0, 0);
    end else if (op == OP_JIF) begin
      if (tv > {1'b0, maxd}) push_ev(1'b0, ST_BIG, sl, 0, 0);
      else begin
        queue_timer(sl, now + tv, h, a);
        push_ev(1'b0, ST_OK, sl, 0, 0);
      end
    end else if (op == OP_SEC) begin
      queue_timer(sl, now + tv * {16'd0, tps}, h, a);
      push_ev(1'b0, ST_OK, sl, 0, 0);
    end else if (op == OP_TEMP) begin
      if (pool.size() == 0) push_ev(1'b0, ST_NOFREE, 0, 0, 0);
      else begin
        s = pool.pop_back();
        dl = tv * {16'd0, tps};
        if (dl > {1'b0, maxd}) begin
          pool.push_back(s);
          push_ev(1'b0, ST_BIG, 0, 0, 0);
        end else begin
          queue_timer(s, now + dl, h, a);
          push_ev(1'b0, ST_OK, s, 0, 0);
        end
      end
    end else if (op == OP_CLEAR) begin
      if (busy[sl]) drop_slot(sl);
      push_ev(1'b0, ST_OK, sl, 0, 0);
    end else if (op == OP_CANCEL) begin
      for (i = 0; i < order.size(); i++)
        if (own_h[order[i]] == h && own_a[order[i]] == a) break;
      if (i < order.size()) begin
        s = order[i];
        push_ev(1'b0, ST_OK, s, own_h[s], own_a[s]);
        retire_at(i);
      end else push_ev(1'b0, ST_NOMATCH, 0, 0, 0);
    end else begin
      push_ev(1'b0, ST_OK, 0, 0, 0);
    end
    if (pending_events.size() > base) pending_events[$].last = 1'b1;
  endfunction

  // receiver with random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      event_t got, want;
      got = {m_tuser, m_tdata[1:0], m_tdata[5:2], m_tdata[13:6], m_tdata[29:14], m_tlast};
      n_events++;
      if (pending_events.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected k%0d st%0d sl%0d h%h a%h l%0d, got k%0d st%0d sl%0d h%h a%h l%0d",
              want.kind, want.status, want.tslot, want.hid, want.harg, want.last,
              got.kind, got.status, got.tslot, got.hid, got.harg, got.last);
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > 400000) begin
      $display("timeout");
      $display("[sorted_timer_queue] ERROR");
      $finish;
    end

  task automatic send(op_t op, logic [3:0] sl, logic [31:0] tv, logic [7:0] h,
                      logic [15:0] a);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, a, h, tv, sl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(op, sl, tv, h, a);
    n_items++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TPS) tps = v[15:0];
    else maxd = v[30:0];
  endtask

  typedef struct {
    op_t op; logic [3:0] sl; logic [31:0] tv; logic [7:0] h; logic [15:0] a;
    bit typed; event_t want;
  } row_t;

  row_t plan [$];

  function automatic row_t mk(op_t op, int sl, logic [31:0] tv, int h, int a);
    row_t r;
    r.op = op; r.sl = sl[3:0]; r.tv = tv; r.h = h[7:0]; r.a = a[15:0];
    r.typed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mkw(op_t op, int sl, logic [31:0] tv, int h, int a,
                               status_t st, int ts);
    row_t r;
    r = mk(op, sl, tv, h, a);
    r.typed = 1;
    r.want = {1'b0, st, ts[3:0], 8'd0, 16'd0, 1'b1};
    return r;
  endfunction

  task automatic random_item(bit shallow);
    int r;
    op_t op;
    logic [31:0] tv;
    r = $urandom_range(0, 99);
    op = r < 35 ? OP_TICK : r < 45 ? OP_ABS : r < 60 ? OP_JIF : r < 68 ? OP_SEC :
         r < 80 ? OP_TEMP : r < 88 ? OP_CLEAR : r < 97 ? OP_CANCEL : OP_NOP;
    case ($urandom_range(0, 5))
      0: tv = $urandom();
      1: tv = now + $urandom_range(0, 8) - 2;
      default: tv = $urandom_range(0, 6);
    endcase
    if (op == OP_JIF && $urandom_range(0, 9) == 0) tv = $urandom() | 32'h8000_0000;
    send(op, $urandom_range(0, 9) == 0 ? $urandom_range(12, 15) : $urandom_range(0, 11),
         tv, shallow ? $urandom_range(0, 3) : $urandom(),
         shallow ? $urandom_range(0, 3) : $urandom());
  endtask

  initial begin
    tps = 100; maxd = 31'h7fff_ffff; now = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      busy[i] = 0; due[i] = 0; own_h[i] = 0; own_a[i] = 0;
    end
    for (int i = 0; i < TEMP_TIMERS; i++) pool.push_back(NUM_TIMERS - 1 - i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(mk(OP_TICK, 0, 0, 0, 0));
    plan.push_back(mkw(OP_CANCEL, 0, 0, 8'hff, 16'hffff, ST_NOMATCH, 0));
    plan.push_back(mkw(OP_CLEAR, 3, 0, 0, 0, ST_OK, 3));
    plan.push_back(mkw(OP_ABS, 15, 32'hffff_ffff, 0, 0, ST_NOMATCH, 15));
    plan.push_back(mkw(OP_JIF, 12, 5, 0, 0, ST_NOMATCH, 12));
    plan.push_back(mkw(OP_NOP, 0, 0, 0, 0, ST_OK, 0));
    plan.push_back(mkw(OP_JIF, 0, 32'hffff_ffff, 1, 1, ST_BIG, 0));
    plan.push_back(mkw(OP_JIF, 11, 32'h7fff_ffff, 8'hff, 16'hffff, ST_OK, 11));
    plan.push_back(mkw(OP_ABS, 1, 3, 8'h11, 16'h1111, ST_OK, 1));
    plan.push_back(mkw(OP_ABS, 2, 3, 8'h22, 16'h2222, ST_OK, 2));
    plan.push_back(mkw(OP_JIF, 0, 0, 8'h33, 16'h3333, ST_OK, 0));
    plan.push_back(mkw(OP_TEMP, 0, 0, 8'h44, 16'h4444, ST_OK, 12));
    plan.push_back(mkw(OP_TEMP, 0, 1, 8'h55, 16'h5555, ST_OK, 13));
    plan.push_back(mkw(OP_TEMP, 0, 2, 8'h66, 16'h6666, ST_OK, 14));
    plan.push_back(mkw(OP_TEMP, 0, 3, 8'h77, 16'h7777, ST_OK, 15));
    plan.push_back(mkw(OP_TEMP, 0, 4, 8'h88, 16'h8888, ST_NOFREE, 0));
    plan.push_back(mk(OP_SEC, 4, 32'hffff_ffff, 8'h99, 16'h9999));
    plan.push_back(mk(OP_CANCEL, 0, 0, 8'h55, 16'h5555));
    plan.push_back(mk(OP_ABS, 1, 2, 8'h12, 16'h1212));
    plan.push_back(mk(OP_TICK, 0, 0, 0, 0));
    plan.push_back(mk(OP_TICK, 0, 0, 0, 0));
    plan.push_back(mk(OP_TICK, 0, 0, 0, 0));
    plan.push_back(mk(OP_CLEAR, 4, 0, 0, 0));
    plan.push_back(mk(OP_TEMP, 0, 32'h0200_0000, 1, 2));
    foreach (plan[i]) begin
      send(plan[i].op, plan[i].sl, plan[i].tv, plan[i].h, plan[i].a);
      if (plan[i].typed) begin
        if (pending_events.size() == 0 || pending_events[$] !== plan[i].want) begin
          errors++;
          $display("table row %0d disagrees with prediction", i);
        end
      end
    end

    // burst of close expiries, so one tick fires more than one timer
    for (int i = 0; i < 12; i++) send(OP_ABS, 4'(i), now + 1, 8'(i), 16'(i));
    for (int i = 0; i < 4; i++) send(OP_TEMP, 4'd0, 32'd0, 8'(8'hf0 + i), 16'(i));
    send(OP_TICK, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TPS, 1); write_reg(CFG_MAXD, 0); end
        1: begin write_reg(CFG_TPS, 16'hffff); write_reg(CFG_MAXD, 32'h7fff_ffff); end
        2: begin write_reg(CFG_TPS, 3); write_reg(CFG_MAXD, 10); end
        3: begin write_reg(CFG_TPS, $urandom_range(1, 4)); write_reg(CFG_MAXD, 20); end
      endcase
      if (ph == 3) calm = 1;
      for (int k = 0; k < 95; k++) random_item(k % 3 == 0);
    end

    while (pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d commands sent, %0d results checked, %0d timer expiries, %0d mismatches",
             n_items, n_events, n_fired, mismatches);
    if (errors == 0) $display("[sorted_timer_queue] OK");
    else $display("[sorted_timer_queue] ERROR");
    $finish;
  end

endmodule

// ===== sorted_timer_queue.f =====
src/stq_pkg.sv
src/stq_ctrl.sv
src/stq_datapath.sv
src/sorted_timer_queue.sv
sim/testbench.sv
